// ===== design/acp_pkg.sv =====
// Package for the ANSI CSI cursor/color parser: payload types, codes,
// and small helper functions. No dependencies.
package acp_pkg;

  localparam int unsigned MaxParams  = 32;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_ERASED = 3'd1,
    KIND_ERASEL = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_CSI   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    LE_UNKNOWN = 2'd0,
    LE_DOS     = 2'd1,
    LE_UNIX    = 2'd2,
    LE_MAC     = 2'd3
  } line_end_e;

  // Operation classes handed from the front end to the back end
  typedef enum logic [1:0] {
    CL_SKIP  = 2'd0,
    CL_DIGIT = 2'd1,
    CL_SEMI  = 2'd2,
    CL_OTHER = 2'd3
  } class_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [15:0] column;
    logic [15:0] row;
    logic [7:0]  attr_color;
    logic [1:0]  erase_mode;
    logic [15:0] width_seen;
    logic [15:0] height_seen;
  } out_item_t;

  // Byte plus decoded class, as queued between front and back end
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
    class_e     cls;
  } op_t;

  localparam logic [7:0] ChEsc = 8'h1B;
  localparam logic [7:0] ChEnd = 8'h1A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [CoordBits-1:0] CoordMax = '1;

  function automatic logic [2:0] ansi_to_ega(input logic [2:0] a);
    logic [2:0] r;
    case (a)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CoordMax}) ? CoordMax : s[15:0];
  endfunction

endpackage

// ===== design/acp_front.sv =====
// Front end: accepts bytes and classifies them for the parameter path.
// Depends on acp_pkg.
module acp_front import acp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t in_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output op_t      op_o,
  output logic     op_valid_o,
  input  logic     op_ready_i
);
  logic [$clog2(QueueDepth+1)-1:0] cnt_q, cnt_d;
  op_t  buf_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_q, rd_q;
  op_t  op_new;
  logic push, pop;

  // classify byte
  always_comb begin
    op_new.text_byte = in_i.text_byte;
    op_new.is_last   = in_i.is_last;
    if (in_i.text_byte >= "0" && in_i.text_byte <= "9") op_new.cls = CL_DIGIT;
    else if (in_i.text_byte == ";") op_new.cls = CL_SEMI;
    else op_new.cls = CL_OTHER;
  end

  assign in_ready_o = (cnt_q != QueueDepth[$bits(cnt_q)-1:0]);
  assign push = in_valid_i && in_ready_o;
  assign op_valid_o = (cnt_q != '0);
  assign pop = op_valid_o && op_ready_i;
  assign op_o = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= op_new;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueDepth[$bits(cnt_q)-1:0]) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");
endmodule

// ===== design/acp_back.sv =====
// Back end: carries out cursor, color and CSI state updates per byte.
// Depends on acp_pkg.
module acp_back import acp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] wrap_col_i,
  input  op_t         op_i,
  input  logic        op_valid_i,
  output logic        op_ready_o,
  output out_item_t   res_o,
  output logic        res_valid_o,
  input  logic        res_ready_i
);
  logic [15:0] col_q, col_d, row_q, row_d, scol_q, scol_d, srow_q, srow_d;
  logic [7:0]  color_q, color_d, tcol_q, tcol_d;
  line_end_e   le_q, le_d;
  logic        crh_q, crh_d, stop_q, stop_d, pp_q, pp_d;
  phase_e      ph_q, ph_d;
  logic [5:0]  pidx_q, pidx_d;
  logic [15:0] acc_q, acc_d;
  logic [16:0] p1_q, p1_d, p2_q, p2_d;
  logic [15:0] mw_q, mw_d, mh_q, mh_d;
  out_item_t   out_q, out_n;
  logic        ov_q, emit;
  logic        step;

  assign res_o = out_q;
  assign res_valid_o = ov_q;
  assign op_ready_o = !ov_q || res_ready_i;
  assign step = op_valid_i && op_ready_o;

  // process one byte
  always_comb begin
    logic [7:0]  b;
    logic [19:0] mul;
    logic [16:0] fp;
    logic [15:0] n, n2;
    b = op_i.text_byte;
    col_d = col_q; row_d = row_q; scol_d = scol_q; srow_d = srow_q;
    color_d = color_q; tcol_d = tcol_q; le_d = le_q; crh_d = crh_q;
    stop_d = stop_q; pp_d = pp_q; ph_d = ph_q; pidx_d = pidx_q;
    acc_d = acc_q; p1_d = p1_q; p2_d = p2_q; mw_d = mw_q; mh_d = mh_q;
    emit = 1'b0;
    out_n = '0;
    mul = '0; fp = '0; n = '0; n2 = '0;
    if (!stop_q) begin
      // resolve held CR
      if (crh_q) begin
        crh_d = 1'b0;
        le_d = (b == ChLf) ? LE_DOS : LE_MAC;
        col_d = '0;
        if (le_d == LE_MAC) row_d = sat_add(row_d, 16'd1);
        if (wrap_col_i != '0 && col_d >= wrap_col_i) begin
          col_d = '0; row_d = sat_add(row_d, 16'd1);
        end
      end
      if (ph_q == PH_ESC && b == "[") begin
        ph_d = PH_CSI; pidx_d = '0; acc_d = '0; pp_d = 1'b0;
        p1_d = '0; p2_d = '0; tcol_d = color_q;
      end else if (ph_q == PH_CSI && op_i.cls == CL_DIGIT) begin
        mul = {4'd0, acc_q} * 20'd10 + {16'd0, b[3:0]};
        acc_d = (mul > 20'hFFFF) ? 16'hFFFF : mul[15:0];
        pp_d = 1'b1;
      end else if (ph_q == PH_CSI && op_i.cls == CL_SEMI &&
                   (!pp_q || ({1'b0, pidx_q} + 7'd1 >= 7'(MaxParams)))) begin
        stop_d = 1'b1; ph_d = PH_PLAIN; emit = 1'b1;
        out_n.kind = KIND_ERROR;
      end else if (ph_q == PH_CSI) begin
        // finish parameter: record and apply SGR
        fp = pp_q ? {1'b1, acc_q} : 17'd0;
        if (pp_q) begin
          if (acc_q == 16'd0) tcol_d = 8'd7;
          else if (acc_q == 16'd1) tcol_d = tcol_q | 8'd8;
          else if (acc_q == 16'd5) tcol_d = tcol_q | 8'd128;
          else if (acc_q >= 16'd30 && acc_q <= 16'd37)
            tcol_d = (tcol_q & 8'd248) | {5'd0, ansi_to_ega(acc_q[2:0] - 3'd6)};
          else if (acc_q >= 16'd40 && acc_q <= 16'd47)
            tcol_d = (tcol_q & 8'd143) | {1'b0, ansi_to_ega(acc_q[2:0]), 4'd0};
        end
        if (pidx_q == 6'd0) p1_d = fp;
        else if (pidx_q == 6'd1) p2_d = fp;
        if (op_i.cls == CL_SEMI) begin
          pidx_d = pidx_q + 6'd1; acc_d = '0; pp_d = 1'b0;
        end else begin
          ph_d = PH_PLAIN;
          n  = (p1_d[16] && p1_d[15:0] != '0) ? p1_d[15:0] : 16'd1;
          n2 = (p2_d[16] && p2_d[15:0] != '0) ? p2_d[15:0] : 16'd1;
          case (b)
            "m": color_d = tcol_d;
            "s": begin scol_d = col_d; srow_d = row_d; end
            "u": begin col_d = scol_q; row_d = srow_q; end
            "J", "K": begin
              emit = 1'b1;
              out_n.kind = (b == "J") ? KIND_ERASED : KIND_ERASEL;
              out_n.erase_mode = !p1_d[16] ? 2'd0 :
                                 (p1_d[15:0] > 16'd2) ? 2'd2 : p1_d[1:0];
            end
            "A", "F": begin
              if (b == "F") col_d = '0;
              row_d = (row_d >= n) ? row_d - n : '0;
            end
            "B", "E": begin
              if (b == "E") col_d = '0;
              row_d = sat_add(row_d, n);
            end
            "C": col_d = sat_add(col_d, n);
            "D": col_d = (col_d >= n) ? col_d - n : '0;
            "G": col_d = n - 16'd1;
            "H", "f": begin row_d = n - 16'd1; col_d = n2 - 16'd1; end
            default: ;
          endcase
        end
      end else if (ph_q == PH_PLAIN && b == ChCr) begin
        if (le_d == LE_UNKNOWN) crh_d = 1'b1;
        else begin
          col_d = '0;
          if (le_d == LE_MAC) row_d = sat_add(row_d, 16'd1);
        end
      end else if (ph_q == PH_PLAIN && b == ChLf) begin
        if (le_d == LE_UNKNOWN) le_d = LE_UNIX;
        if (le_d == LE_UNIX) col_d = '0;
        row_d = sat_add(row_d, 16'd1);
      end else if (ph_q == PH_PLAIN && b == ChEnd) begin
        stop_d = 1'b1; emit = 1'b1; out_n.kind = KIND_END;
      end else if (ph_q == PH_PLAIN && b == ChEsc) begin
        le_d = LE_DOS; ph_d = PH_ESC;
      end else begin
        // place character
        ph_d = PH_PLAIN;
        if (sat_add(col_d, 16'd1) > mw_q) mw_d = sat_add(col_d, 16'd1);
        if (sat_add(row_d, 16'd1) > mh_q) mh_d = sat_add(row_d, 16'd1);
        emit = 1'b1; out_n.kind = KIND_CHAR; out_n.char_code = b;
        out_n.column = col_d; out_n.row = row_d;
        col_d = sat_add(col_d, 16'd1);
      end
      out_n.attr_color = color_d;
      if (out_n.kind != KIND_CHAR) begin
        out_n.column = col_d; out_n.row = row_d;
      end
      out_n.width_seen = mw_d; out_n.height_seen = mh_d;
      if (!stop_d && wrap_col_i != '0 && col_d >= wrap_col_i) begin
        col_d = '0; row_d = sat_add(row_d, 16'd1);
      end
    end
  end

  // commit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; scol_q <= '0; srow_q <= '0;
      color_q <= 8'd7; tcol_q <= 8'd7; le_q <= LE_UNKNOWN; crh_q <= 1'b0;
      ph_q <= PH_PLAIN; pidx_q <= '0; acc_q <= '0; pp_q <= 1'b0;
      p1_q <= '0; p2_q <= '0; stop_q <= 1'b0; mw_q <= '0; mh_q <= '0;
      ov_q <= 1'b0;
    end else begin
      ov_q <= (step && emit) || (ov_q && !res_ready_i);
      if (step) begin
        if (op_i.is_last) begin
          col_q <= '0; row_q <= '0; scol_q <= '0; srow_q <= '0;
          color_q <= 8'd7; tcol_q <= 8'd7; le_q <= LE_UNKNOWN; crh_q <= 1'b0;
          ph_q <= PH_PLAIN; pidx_q <= '0; acc_q <= '0; pp_q <= 1'b0;
          p1_q <= '0; p2_q <= '0; stop_q <= 1'b0; mw_q <= '0; mh_q <= '0;
        end else begin
          col_q <= col_d; row_q <= row_d; scol_q <= scol_d; srow_q <= srow_d;
          color_q <= color_d; tcol_q <= tcol_d; le_q <= le_d; crh_q <= crh_d;
          ph_q <= ph_d; pidx_q <= pidx_d; acc_q <= acc_d; pp_q <= pp_d;
          p1_q <= p1_d; p2_q <= p2_d; stop_q <= stop_d; mw_q <= mw_d; mh_q <= mh_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) out_q <= out_n;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !res_ready_i) |-> !step) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && stop_q) |-> !emit) else $error("output while stopped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    crh_q |-> (le_q == LE_UNKNOWN)) else $error("CR held with known style");
endmodule

// ===== design/ansi_csi_cursor_color_parser.sv =====
// Top level of the ANSI CSI cursor/color parser.
// Depends on acp_pkg, acp_front, acp_back.
//
//  channel  | handshake   | payload
//  input    | push / full | in_item_i  (text_byte, is_last)
//  result   | pop / empty | out_item_o (kind .. height_seen)
//  config   | cfg_we_i    | cfg_wdata_i (wrap column)
//
// One byte per cycle sustained while results are popped; the back end updates all its state per byte.
// A byte is written into the front-end queue; its result is registered in the back end when it takes the byte.
// Reset empties the queue and clears all parser state; the wrap column resets to 0.
// A stalled result holds the back end; the queue then absorbs up to two more bytes.
module ansi_csi_cursor_color_parser import acp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  logic        push,
  output logic        full,
  output out_item_t   out_item_o,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  logic [15:0] wrap_q;
  op_t  op;
  logic op_valid, op_ready, in_ready, res_valid;

  // hold the wrap column register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wrap_q <= '0;
    else if (cfg_we_i) wrap_q <= cfg_wdata_i;
  end

  assign full  = !in_ready;
  assign empty = !res_valid;

  acp_front u_front (
    .clk_i, .rst_ni, .in_i(in_item_i), .in_valid_i(push), .in_ready_o(in_ready),
    .op_o(op), .op_valid_o(op_valid), .op_ready_i(op_ready)
  );

  acp_back u_back (
    .clk_i, .rst_ni, .wrap_col_i(wrap_q), .op_i(op), .op_valid_i(op_valid),
    .op_ready_o(op_ready), .res_o(out_item_o), .res_valid_o(res_valid),
    .res_ready_i(pop)
  );
endmodule
